/* rtl/core/csvfnc_pkg.sv */
// Shared types and constants for the CSV field numeric classifier.
`timescale 1ns / 1ps
`default_nettype none

package csvfnc_pkg;

  localparam int VALUE_BITS_DEF = 64;
  localparam int BOUND_W        = 63;
  localparam int REG_IDX_W      = 2;
  localparam int EXP_W          = 32;

  // Register indexes on the configuration port
  localparam logic [REG_IDX_W-1:0] REG_INT_BOUND       = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_LONG_BOUND      = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_LONG_LONG_BOUND = 2'd2;

  localparam logic [BOUND_W-1:0] INT_BOUND_RST       = 63'd2147483647;
  localparam logic [BOUND_W-1:0] LONG_BOUND_RST      = '1;
  localparam logic [BOUND_W-1:0] LONG_LONG_BOUND_RST = '1;

  // Result type codes
  localparam logic [2:0] TYPE_NULL      = 3'd0;
  localparam logic [2:0] TYPE_STRING    = 3'd1;
  localparam logic [2:0] TYPE_INT       = 3'd2;
  localparam logic [2:0] TYPE_LONG      = 3'd3;
  localparam logic [2:0] TYPE_LONG_LONG = 3'd4;
  localparam logic [2:0] TYPE_DOUBLE    = 3'd5;

  // Characters the scanner reacts to
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_E_LO  = 8'h65;
  localparam logic [7:0] CH_E_UP  = 8'h45;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Exponent magnitude cap before the sign is applied
  localparam logic [EXP_W-1:0] EXP_CAP     = 32'h8000_0000;
  localparam logic [EXP_W-1:0] EXP_POS_MAX = 32'h7FFF_FFFF;
  localparam logic [5:0]       PLACES_MAX  = 6'd63;

  // Per-segment permission and status flags
  typedef struct packed {
    logic flt;     // point seen
    logic has;     // digit seen
    logic digit;   // digits allowed
    logic dot;     // point allowed
    logic neg;     // minus allowed
    logic ws;      // spaces allowed
  } seg_flags_t;

  localparam seg_flags_t SF_RESET = '{flt: 1'b0, has: 1'b0, digit: 1'b1,
                                      dot: 1'b1, neg: 1'b1, ws: 1'b1};

  typedef struct packed {
    logic [7:0] character;
    logic       is_last;
    logic       field_empty;
  } item_t;

  typedef struct packed {
    logic [2:0]        type_code;
    logic              negative;
    logic [63:0]       integer_value;
    logic              integer_saturated;
    logic [63:0]       fraction_value;
    logic [5:0]        fraction_places;
    logic signed [31:0] exponent_value;
    logic              value_exact;
  } result_t;

endpackage

`default_nettype wire

/* rtl/core/csv_field_numeric_classifier_core.sv */
// Top level: per-character CSV field scanner with numeric type classification.
`timescale 1ns / 1ps
`default_nettype none

// Takes one character of a CSV field per transfer and, on the field's last
// character (or an empty-field marker), delivers one result: the field type
// (null, string, int, long, long long, double) plus sign, integer digits,
// fraction digits, fraction places and decimal exponent. Non-final characters
// produce no result. A new character is accepted every clock cycle; result_valid
// is set when the field's last character passes from the input register to the
// result register. The rate is set by the update of the field state (flags and
// multiply-by-ten accumulators) from the registered character. Input stalls
// only while a finished result waits in the output register and the next field
// end is up.
// The bound registers may be written only while the block is idle.
module csv_field_numeric_classifier_core #(
  parameter int VALUE_BITS = csvfnc_pkg::VALUE_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_write,
  input  wire logic [csvfnc_pkg::REG_IDX_W-1:0]  cfg_index,
  input  wire logic [csvfnc_pkg::BOUND_W-1:0]    cfg_data,
  input  wire logic                              item_valid,
  output logic                                   item_ready,
  input  wire csvfnc_pkg::item_t                 item,
  output logic                                   result_valid,
  input  wire logic                              result_ready,
  output csvfnc_pkg::result_t                    result
);

  localparam int PW = VALUE_BITS + 4;
  localparam int EW = csvfnc_pkg::EXP_W;
  localparam logic [VALUE_BITS-1:0] VMAX = '1;

  // Bound registers
  logic [csvfnc_pkg::BOUND_W-1:0] int_bound, long_bound, long_long_bound;

  // Input stage
  logic               item_v;
  csvfnc_pkg::item_t  item_r;

  // Field state
  csvfnc_pkg::seg_flags_t seg_flags, seg_flags_next;
  logic                   prev_digit, prev_digit_next;
  logic                   rejected, rejected_next;
  logic [1:0]             exp_level, exp_level_next;
  logic                   plus_skip, plus_skip_next;
  logic                   mant_neg, mant_neg_next;
  logic [VALUE_BITS-1:0]  int_acc, int_acc_next;
  logic                   int_sat, int_sat_next;
  logic [VALUE_BITS-1:0]  frac_acc, frac_acc_next;
  logic                   frac_sat, frac_sat_next;
  logic [5:0]             frac_cnt, frac_cnt_next;
  logic                   places_sat, places_sat_next;
  logic [EW-1:0]          exp_acc, exp_acc_next;
  logic                   exp_sat, exp_sat_next;
  logic                   exp_neg, exp_neg_next;
  logic                   exp_frac_nz, exp_frac_nz_next;

  logic                   need_res, advance;
  csvfnc_pkg::result_t    result_next;

  assign need_res   = item_r.is_last | item_r.field_empty;
  assign advance    = item_v & (~need_res | ~result_valid | result_ready);
  assign item_ready = ~item_v | advance;

  // Digit arithmetic: acc*10 + d, overflow when the product passes the cap
  logic [7:0]    ch;
  logic          is_dig;
  logic [3:0]    dval;
  logic [PW-1:0] int_ext, int_prod, frac_ext, frac_prod;
  logic          int_ovf, frac_ovf;
  logic [EW+3:0] exp_ext, exp_prod;
  logic          exp_ovf;

  assign ch     = item_r.character;
  assign is_dig = (ch >= csvfnc_pkg::CH_ZERO) && (ch <= csvfnc_pkg::CH_NINE);
  assign dval   = ch[3:0];

  assign int_ext   = PW'(int_acc);
  assign int_prod  = (int_ext << 3) + (int_ext << 1) + PW'(dval);
  assign int_ovf   = |int_prod[PW-1:VALUE_BITS];
  assign frac_ext  = PW'(frac_acc);
  assign frac_prod = (frac_ext << 3) + (frac_ext << 1) + PW'(dval);
  assign frac_ovf  = |frac_prod[PW-1:VALUE_BITS];
  assign exp_ext   = (EW+4)'(exp_acc);
  assign exp_prod  = (exp_ext << 3) + (exp_ext << 1) + (EW+4)'(dval);
  assign exp_ovf   = exp_prod > (EW+4)'(csvfnc_pkg::EXP_CAP);

  // Field state update for the registered character
  always_comb begin
    logic skip;
    skip             = 1'b0;
    seg_flags_next   = seg_flags;
    prev_digit_next  = prev_digit;
    rejected_next    = rejected;
    exp_level_next   = exp_level;
    plus_skip_next   = plus_skip;
    mant_neg_next    = mant_neg;
    int_acc_next     = int_acc;
    int_sat_next     = int_sat;
    frac_acc_next    = frac_acc;
    frac_sat_next    = frac_sat;
    frac_cnt_next    = frac_cnt;
    places_sat_next  = places_sat;
    exp_acc_next     = exp_acc;
    exp_sat_next     = exp_sat;
    exp_neg_next     = exp_neg;
    exp_frac_nz_next = exp_frac_nz;
    if (!rejected) begin
      // one '+' may directly follow an exponent mark
      if (plus_skip) begin
        plus_skip_next = 1'b0;
        if (ch == csvfnc_pkg::CH_PLUS) begin
          prev_digit_next = 1'b0;
          skip            = 1'b1;
        end
      end
      if (!skip) begin
        prev_digit_next = is_dig;
        if (ch == csvfnc_pkg::CH_SPACE) begin
          if (!seg_flags.ws) begin
            if (prev_digit) begin
              seg_flags_next.digit = 1'b0;
              seg_flags_next.ws    = 1'b1;
            end else begin
              rejected_next = 1'b1;
            end
          end
        end else if (ch == csvfnc_pkg::CH_MINUS) begin
          if (!seg_flags.neg) rejected_next = 1'b1;
          else seg_flags_next.neg = 1'b0;
        end else if (ch == csvfnc_pkg::CH_POINT) begin
          if (!seg_flags.dot) begin
            rejected_next = 1'b1;
          end else begin
            seg_flags_next.dot = 1'b0;
            seg_flags_next.flt = 1'b1;
          end
        end else if (ch == csvfnc_pkg::CH_E_LO || ch == csvfnc_pkg::CH_E_UP) begin
          if (!seg_flags.flt) begin
            rejected_next = 1'b1;
          end else begin
            if (exp_level == 2'd0) mant_neg_next = ~seg_flags.neg;
            else if (exp_level == 2'd1) exp_neg_next = ~seg_flags.neg;
            if (exp_level != 2'd2) exp_level_next = exp_level + 2'd1;
            seg_flags_next  = csvfnc_pkg::SF_RESET;
            plus_skip_next  = 1'b1;
            prev_digit_next = 1'b0;
          end
        end else if (is_dig) begin
          seg_flags_next.has = 1'b1;
          if (!seg_flags.digit) begin
            rejected_next = 1'b1;
          end else begin
            seg_flags_next.ws = 1'b0;
            if (exp_level == 2'd0) begin
              if (seg_flags.flt) begin
                if (!frac_sat) begin
                  if (frac_ovf) begin
                    frac_acc_next = VMAX;
                    frac_sat_next = 1'b1;
                  end else begin
                    frac_acc_next = frac_prod[VALUE_BITS-1:0];
                  end
                end
                if (frac_cnt == csvfnc_pkg::PLACES_MAX) places_sat_next = 1'b1;
                else frac_cnt_next = frac_cnt + 6'd1;
              end else if (!int_sat) begin
                if (int_ovf) begin
                  int_acc_next = VMAX;
                  int_sat_next = 1'b1;
                end else begin
                  int_acc_next = int_prod[VALUE_BITS-1:0];
                end
              end
            end else if (exp_level == 2'd1) begin
              if (seg_flags.flt) begin
                if (dval != 4'd0) exp_frac_nz_next = 1'b1;
              end else if (!exp_sat) begin
                if (exp_ovf) begin
                  exp_acc_next = csvfnc_pkg::EXP_CAP;
                  exp_sat_next = 1'b1;
                end else begin
                  exp_acc_next = exp_prod[EW-1:0];
                end
              end
            end
          end
        end else begin
          rejected_next = 1'b1;
        end
      end
    end
  end

  // Field-end classification from the updated state
  always_comb begin
    logic [2:0]    tcode;
    logic          neg_f, eneg_f, esat_f, exact_f;
    logic [EW-1:0] expo;
    tcode  = csvfnc_pkg::TYPE_NULL;
    neg_f  = 1'b0;
    eneg_f = exp_neg_next;
    if (item_r.field_empty) begin
      tcode = csvfnc_pkg::TYPE_NULL;
    end else if (rejected_next) begin
      tcode = csvfnc_pkg::TYPE_STRING;
    end else if (exp_level_next == 2'd0) begin
      if (seg_flags_next.has) begin
        neg_f = ~seg_flags_next.neg;
        if (seg_flags_next.flt || int_sat_next)
          tcode = csvfnc_pkg::TYPE_DOUBLE;
        else if (64'(int_acc_next) < {1'b0, int_bound})
          tcode = csvfnc_pkg::TYPE_INT;
        else if (64'(int_acc_next) < {1'b0, long_bound})
          tcode = csvfnc_pkg::TYPE_LONG;
        else if (64'(int_acc_next) < {1'b0, long_long_bound})
          tcode = csvfnc_pkg::TYPE_LONG_LONG;
        else
          tcode = csvfnc_pkg::TYPE_DOUBLE;
      end
    end else if (seg_flags_next.has) begin
      tcode = csvfnc_pkg::TYPE_DOUBLE;
      neg_f = mant_neg_next;
      if (exp_level_next == 2'd1) eneg_f = ~seg_flags_next.neg;
    end else begin
      tcode = csvfnc_pkg::TYPE_STRING;
    end

    esat_f = exp_sat_next;
    if (eneg_f) begin
      expo = EW'(0) - exp_acc_next;
    end else if (exp_acc_next[EW-1]) begin
      expo   = csvfnc_pkg::EXP_POS_MAX;
      esat_f = 1'b1;
    end else begin
      expo = exp_acc_next;
    end
    exact_f = ~(int_sat_next | frac_sat_next | places_sat_next | esat_f |
                exp_level_next[1] | exp_frac_nz_next);

    result_next           = '0;
    result_next.type_code = tcode;
    if (tcode != csvfnc_pkg::TYPE_NULL && tcode != csvfnc_pkg::TYPE_STRING) begin
      result_next.negative          = neg_f;
      result_next.integer_value     = 64'(int_acc_next);
      result_next.integer_saturated = int_sat_next;
      result_next.fraction_value    = 64'(frac_acc_next);
      result_next.fraction_places   = frac_cnt_next;
      result_next.exponent_value    = expo;
      result_next.value_exact       = exact_f;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      int_bound       <= csvfnc_pkg::INT_BOUND_RST;
      long_bound      <= csvfnc_pkg::LONG_BOUND_RST;
      long_long_bound <= csvfnc_pkg::LONG_LONG_BOUND_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        csvfnc_pkg::REG_INT_BOUND:       int_bound       <= cfg_data;
        csvfnc_pkg::REG_LONG_BOUND:      long_bound      <= cfg_data;
        csvfnc_pkg::REG_LONG_LONG_BOUND: long_long_bound <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_v <= 1'b0;
    end else if (item_valid && item_ready) begin
      item_v <= 1'b1;
    end else if (advance) begin
      item_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) item_r <= item;
  end

  // Field state: cleared at reset and after every field end
  always_ff @(posedge clk) begin
    if (rst || (advance && need_res)) begin
      seg_flags   <= csvfnc_pkg::SF_RESET;
      prev_digit  <= 1'b0;
      rejected    <= 1'b0;
      exp_level   <= 2'd0;
      plus_skip   <= 1'b0;
      mant_neg    <= 1'b0;
      int_acc     <= '0;
      int_sat     <= 1'b0;
      frac_acc    <= '0;
      frac_sat    <= 1'b0;
      frac_cnt    <= '0;
      places_sat  <= 1'b0;
      exp_acc     <= '0;
      exp_sat     <= 1'b0;
      exp_neg     <= 1'b0;
      exp_frac_nz <= 1'b0;
    end else if (advance) begin
      seg_flags   <= seg_flags_next;
      prev_digit  <= prev_digit_next;
      rejected    <= rejected_next;
      exp_level   <= exp_level_next;
      plus_skip   <= plus_skip_next;
      mant_neg    <= mant_neg_next;
      int_acc     <= int_acc_next;
      int_sat     <= int_sat_next;
      frac_acc    <= frac_acc_next;
      frac_sat    <= frac_sat_next;
      frac_cnt    <= frac_cnt_next;
      places_sat  <= places_sat_next;
      exp_acc     <= exp_acc_next;
      exp_sat     <= exp_sat_next;
      exp_neg     <= exp_neg_next;
      exp_frac_nz <= exp_frac_nz_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance && need_res) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && need_res) result <= result_next;
  end

  // Checks
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !item_v && !result_valid && !rejected && exp_level == 2'd0)
    else $error("field state not cleared by reset");

  a_stall_only_on_full_out: assert property (@(posedge clk) disable iff (rst)
    !item_ready |-> result_valid && !result_ready)
    else $error("input stalled without a pending result");

  a_no_value_on_text: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.type_code == csvfnc_pkg::TYPE_NULL ||
                     result.type_code == csvfnc_pkg::TYPE_STRING)
    |-> result.integer_value == '0 && result.exponent_value == '0 &&
        !result.value_exact && !result.negative)
    else $error("null or string result carries value fields");

  a_int_sat_double: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.integer_saturated
    |-> result.type_code == csvfnc_pkg::TYPE_DOUBLE && !result.value_exact)
    else $error("saturated integer not reported as inexact double");

  a_mantissa_no_exp: assert property (@(posedge clk) disable iff (rst)
    exp_level == 2'd0 |-> exp_acc == '0 && !exp_neg && !exp_frac_nz)
    else $error("exponent state set while still in mantissa");

endmodule

`default_nettype wire

/* tb/csv_field_numeric_classifier_core_tb.sv */
// Self-checking testbench for csv_field_numeric_classifier_core: scanner model, driver, monitor.
`timescale 1ns / 1ps

module csv_field_numeric_classifier_core_tb;
  import csvfnc_pkg::*;

  typedef logic [7:0] ch_t;

  localparam int STALL_LIMIT = 2000;
  localparam int CHARS_PER_PHASE = 181;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_write = 1'b0;
  logic [REG_IDX_W-1:0] cfg_index = '0;
  logic [BOUND_W-1:0]   cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  item_t                in_item = '0;
  logic                 res_valid;
  logic                 res_ready = 1'b0;
  result_t              res_data;

  csv_field_numeric_classifier_core uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_valid   (in_valid),
    .item_ready   (in_ready),
    .item         (in_item),
    .result_valid (res_valid),
    .result_ready (res_ready),
    .result       (res_data)
  );

  always #5 clk = ~clk;

  item_t   chars_to_send[$];
  result_t results_due[$];
  ch_t     txt[$];
  int      chars_queued = 0;
  int      send_idle_pct = 0;
  int      recv_stall_pct = 0;
  int      mismatch_count = 0;
  int      quiet_cycles = 0;

  // Scanner state mirrored from the block
  seg_flags_t   seg;
  bit           prev_digit, rejected, plus_pending, mant_neg, exp_neg, exp_frac_nz;
  bit           int_sat, frac_sat, places_sat, exp_sat;
  logic [1:0]   exp_level;
  logic [63:0]  int_acc, frac_acc, exp_acc;
  logic [5:0]   frac_count;
  logic [BOUND_W-1:0] bound_int, bound_long, bound_ll;

  function automatic void reset_scan();
    seg = SF_RESET;
    prev_digit = 0;
    rejected = 0;
    plus_pending = 0;
    mant_neg = 0;
    exp_neg = 0;
    exp_frac_nz = 0;
    int_sat = 0;
    frac_sat = 0;
    places_sat = 0;
    exp_sat = 0;
    exp_level = 0;
    int_acc = '0;
    frac_acc = '0;
    exp_acc = '0;
    frac_count = '0;
  endfunction

  function automatic logic [63:0] times_ten_plus(input logic [63:0] acc, input logic [3:0] dgt,
                                                 input logic [63:0] cap, inout bit sat);
    if (sat) return acc;
    if (acc > (cap - 64'(dgt)) / 64'd10) begin
      sat = 1;
      return cap;
    end
    return acc * 64'd10 + 64'(dgt);
  endfunction

  function automatic void scan_char(input ch_t c);
    bit         is_dig, was_dig;
    logic [3:0] dgt;
    is_dig = (c >= CH_ZERO) && (c <= CH_NINE);
    was_dig = prev_digit;
    dgt = 4'(c - CH_ZERO);
    if (plus_pending) begin
      plus_pending = 0;
      if (c == CH_PLUS) begin
        prev_digit = 0;
        return;
      end
    end
    prev_digit = is_dig;
    if (c == CH_SPACE) begin
      if (!seg.ws) begin
        // trailing padding only right after a digit
        if (was_dig) begin
          seg.digit = 0;
          seg.ws = 1;
        end else begin
          rejected = 1;
        end
      end
    end else if (c == CH_MINUS) begin
      if (!seg.neg) rejected = 1;
      else seg.neg = 0;
    end else if (c == CH_POINT) begin
      if (!seg.dot) begin
        rejected = 1;
      end else begin
        seg.dot = 0;
        seg.flt = 1;
      end
    end else if (c == CH_E_LO || c == CH_E_UP) begin
      if (!seg.flt) begin
        rejected = 1;
      end else begin
        if (exp_level == 0) mant_neg = !seg.neg;
        else if (exp_level == 1) exp_neg = !seg.neg;
        if (exp_level < 2) exp_level++;
        seg = SF_RESET;
        plus_pending = 1;
        prev_digit = 0;
      end
    end else if (is_dig) begin
      seg.has = 1;
      if (!seg.digit) begin
        rejected = 1;
      end else begin
        seg.ws = 0;
        if (exp_level == 0) begin
          if (seg.flt) begin
            frac_acc = times_ten_plus(frac_acc, dgt, '1, frac_sat);
            if (frac_count == PLACES_MAX) places_sat = 1;
            else frac_count++;
          end else begin
            int_acc = times_ten_plus(int_acc, dgt, '1, int_sat);
          end
        end else if (exp_level == 1) begin
          if (seg.flt) begin
            if (dgt != 0) exp_frac_nz = 1;
          end else begin
            exp_acc = times_ten_plus(exp_acc, dgt, 64'(EXP_CAP), exp_sat);
          end
        end
      end
    end else begin
      rejected = 1;
    end
  endfunction

  // Called for every accepted transfer; a field end queues its result.
  function automatic void predict_char(input item_t it);
    result_t    r;
    logic [2:0] ty;
    bit         neg, esat;
    ty = TYPE_NULL;
    neg = 0;
    if (!it.field_empty) begin
      if (!rejected) scan_char(it.character);
      if (!it.is_last) return;
      if (rejected) begin
        ty = TYPE_STRING;
      end else if (exp_level == 0) begin
        if (seg.has) begin
          neg = !seg.neg;
          if (seg.flt || int_sat) ty = TYPE_DOUBLE;
          else if (int_acc < 64'(bound_int)) ty = TYPE_INT;
          else if (int_acc < 64'(bound_long)) ty = TYPE_LONG;
          else if (int_acc < 64'(bound_ll)) ty = TYPE_LONG_LONG;
          else ty = TYPE_DOUBLE;
        end
      end else if (seg.has) begin
        ty = TYPE_DOUBLE;
        neg = mant_neg;
        if (exp_level == 1) exp_neg = !seg.neg;
      end else begin
        ty = TYPE_STRING;
      end
    end
    r = '0;
    r.type_code = ty;
    if (ty >= TYPE_INT) begin
      esat = exp_sat;
      if (exp_neg) begin
        r.exponent_value = 32'(64'd0 - exp_acc);
      end else if (exp_acc > 64'(EXP_POS_MAX)) begin
        r.exponent_value = EXP_POS_MAX;
        esat = 1;
      end else begin
        r.exponent_value = exp_acc[31:0];
      end
      r.negative = neg;
      r.integer_value = int_acc;
      r.integer_saturated = int_sat;
      r.fraction_value = frac_acc;
      r.fraction_places = frac_count;
      r.value_exact = !(int_sat || frac_sat || places_sat || esat ||
                        exp_level >= 2 || exp_frac_nz);
    end
    results_due.push_back(r);
    reset_scan();
  endfunction

  // ---------------- stimulus builders ----------------

  function automatic void queue_field();
    item_t it;
    if (txt.size() == 0) begin
      it = '0;
      it.field_empty = 1'b1;
      it.is_last = 1'b1;
      chars_to_send.push_back(it);
      chars_queued++;
      return;
    end
    for (int i = 0; i < txt.size(); i++) begin
      it.character = txt[i];
      it.is_last = (i == txt.size() - 1);
      it.field_empty = 1'b0;
      chars_to_send.push_back(it);
      chars_queued++;
    end
  endfunction

  function automatic void queue_text(input string s);
    txt.delete();
    for (int i = 0; i < s.len(); i++) txt.push_back(s[i]);
    queue_field();
  endfunction

  function automatic void add_digits(input int n);
    for (int i = 0; i < n; i++) txt.push_back(ch_t'(CH_ZERO + $urandom_range(0, 9)));
  endfunction

  function automatic void add_spaces(input int n);
    for (int i = 0; i < n; i++) txt.push_back(CH_SPACE);
  endfunction

  function automatic void add_decimal(input logic [63:0] v);
    string s;
    s = $sformatf("%0d", v);
    for (int i = 0; i < s.len(); i++) txt.push_back(s[i]);
  endfunction

  // values around the classification and saturation thresholds
  function automatic logic [63:0] near_bound();
    logic [63:0] base;
    case ($urandom_range(0, 4))
      0: base = 64'(bound_int);
      1: base = 64'(bound_long);
      2: base = 64'(bound_ll);
      3: base = '1;
      default: base = 64'(INT_BOUND_RST);
    endcase
    return base - 64'd2 + 64'($urandom_range(0, 4));
  endfunction

  function automatic ch_t rand_char();
    case ($urandom_range(0, 9))
      0: return CH_SPACE;
      1: return CH_MINUS;
      2: return CH_POINT;
      3: return CH_E_LO;
      4: return CH_E_UP;
      5: return CH_PLUS;
      6, 7: return ch_t'(CH_ZERO + $urandom_range(0, 9));
      default: return ch_t'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void add_exponent();
    int r;
    txt.push_back($urandom_range(0, 1) ? CH_E_LO : CH_E_UP);
    if ($urandom_range(0, 1)) txt.push_back(CH_PLUS);
    if ($urandom_range(0, 3) == 0) txt.push_back(CH_MINUS);
    r = $urandom_range(0, 99);
    if (r < 8) begin
      // no exponent digits
    end else if (r < 82) begin
      add_digits($urandom_range(1, 3));
    end else if (r < 91) begin
      add_decimal(64'd2147483646 + 64'($urandom_range(0, 3)));
    end else begin
      add_digits($urandom_range(9, 12));
    end
    if ($urandom_range(0, 4) == 0) begin
      txt.push_back(CH_POINT);
      add_digits($urandom_range(0, 3));
      if ($urandom_range(0, 2) == 0) begin
        txt.push_back($urandom_range(0, 1) ? CH_E_LO : CH_E_UP);
        if ($urandom_range(0, 1)) txt.push_back(CH_MINUS);
        add_digits($urandom_range(0, 2));
      end
    end
  endfunction

  function automatic void gen_number();
    int r, sign_at;
    txt.delete();
    sign_at = $urandom_range(0, 5);
    if ($urandom_range(0, 3) == 0) add_spaces($urandom_range(1, 2));
    if (sign_at == 1) txt.push_back(CH_MINUS);
    r = $urandom_range(0, 99);
    if (r < 10) begin
      // fraction-only or empty mantissa
    end else if (r < 55) begin
      add_digits($urandom_range(1, 4));
    end else if (r < 70) begin
      add_digits($urandom_range(5, 12));
    end else if (r < 80) begin
      add_digits($urandom_range(13, 22));
    end else begin
      add_decimal(near_bound());
    end
    if (sign_at == 2) txt.push_back(CH_MINUS);
    if ($urandom_range(0, 1)) begin
      txt.push_back(CH_POINT);
      r = $urandom_range(0, 99);
      if (r < 82) add_digits($urandom_range(0, 6));
      else if (r < 93) add_digits($urandom_range(15, 21));
      else add_digits($urandom_range(60, 66));
      if (sign_at == 3) txt.push_back(CH_MINUS);
      if ($urandom_range(0, 99) < 45) add_exponent();
    end
    if ($urandom_range(0, 3) == 0) add_spaces($urandom_range(1, 2));
    if (sign_at == 4) txt.push_back(CH_MINUS);
  endfunction

  function automatic void gen_field();
    int    r;
    item_t it;
    r = $urandom_range(0, 99);
    if (r < 62) begin
      gen_number();
    end else if (r < 75) begin
      gen_number();
      if (txt.size() == 0) txt.push_back(rand_char());
      else txt[$urandom_range(0, txt.size() - 1)] = rand_char();
    end else if (r < 86) begin
      txt.delete();
      repeat ($urandom_range(1, 6)) txt.push_back(rand_char());
    end else begin
      // empty-field marker, sometimes after an unfinished field it must drop
      if (r >= 93) begin
        gen_number();
        if (txt.size() == 0) add_digits(1);
        foreach (txt[i]) begin
          it.character = txt[i];
          it.is_last = 1'b0;
          it.field_empty = 1'b0;
          chars_to_send.push_back(it);
          chars_queued++;
        end
      end
      it.character = ch_t'($urandom_range(0, 255));
      it.is_last = 1'($urandom_range(0, 1));
      it.field_empty = 1'b1;
      chars_to_send.push_back(it);
      chars_queued++;
      return;
    end
    queue_field();
  endfunction

  // ---------------- driver ----------------

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) predict_char(in_item);
      if (!in_valid || in_ready) begin
        if (chars_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_item <= chars_to_send.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------- monitor ----------------

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      res_ready <= 1'b0;
    end else begin
      res_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      if (res_valid && res_ready) begin
        if (results_due.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result transfer: type %0d int %0d",
                     res_data.type_code, res_data.integer_value);
        end else begin
          want = results_due.pop_front();
          if (res_data !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display({"result mismatch (exp/got): type %0d/%0d neg %0d/%0d int %0d/%0d",
                        " isat %0d/%0d frac %0d/%0d places %0d/%0d exp %0d/%0d",
                        " exact %0d/%0d"},
                       want.type_code, res_data.type_code, want.negative, res_data.negative,
                       want.integer_value, res_data.integer_value,
                       want.integer_saturated, res_data.integer_saturated,
                       want.fraction_value, res_data.fraction_value,
                       want.fraction_places, res_data.fraction_places,
                       want.exponent_value, res_data.exponent_value,
                       want.value_exact, res_data.value_exact);
          end
        end
      end
    end
  end

  // watchdog: cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (res_valid && res_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("csv_field_numeric_classifier_core regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------- sequencing ----------------

  task automatic wait_all_results();
    while (chars_to_send.size() != 0 || in_valid || results_due.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [BOUND_W-1:0] v);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    case (idx)
      REG_INT_BOUND:  bound_int = v;
      REG_LONG_BOUND: bound_long = v;
      default:        bound_ll = v;
    endcase
  endtask

  task automatic write_bounds(input logic [BOUND_W-1:0] b_int, b_long, b_ll);
    write_reg(REG_INT_BOUND, b_int);
    write_reg(REG_LONG_BOUND, b_long);
    write_reg(REG_LONG_LONG_BOUND, b_ll);
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  function automatic logic [BOUND_W-1:0] rand_bound();
    return BOUND_W'({$urandom, $urandom} >> $urandom_range(1, 63));
  endfunction

  initial begin
    int    target;
    item_t it;
    reset_scan();
    bound_int = INT_BOUND_RST;
    bound_long = LONG_BOUND_RST;
    bound_ll = LONG_LONG_BOUND_RST;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed fields under reset bounds
    txt.delete();
    queue_field();
    queue_text("0");
    queue_text("9");
    queue_text("-");
    queue_text("1.");
    queue_text("1.e");
    queue_text("1e");
    queue_text(".e.e1");
    queue_text(".E+1");
    txt.delete();
    txt.push_back(8'hFF);
    queue_field();
    txt.delete();
    txt.push_back(8'h00);
    queue_field();
    it.character = CH_ZERO + 8'd5;
    it.is_last = 1'b0;
    it.field_empty = 1'b0;
    chars_to_send.push_back(it);
    txt.delete();
    queue_field();

    for (int p = 0; p < 8; p++) begin
      wait_all_results();
      case (p)
        0: write_bounds(INT_BOUND_RST, LONG_BOUND_RST, LONG_LONG_BOUND_RST);
        1: write_bounds('0, '0, '0);
        2: write_bounds('1, '1, '1);
        3: write_bounds(63'd100, 63'd100000, 63'd10000000000);
        6: write_bounds(63'd1000, 63'd10, 63'd5);
        default: write_bounds(rand_bound(), rand_bound(), rand_bound());
      endcase
      send_idle_pct = (p % 4 == 1) ? 57 : (p % 4 == 3) ? 13 : 0;
      recv_stall_pct = (p % 4 == 2) ? 57 : (p % 4 == 3) ? 13 : 0;
      target = chars_queued + CHARS_PER_PHASE;
      while (chars_queued < target) gen_field();
    end

    wait_all_results();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("csv_field_numeric_classifier_core regression: pass");
    end else begin
      $display("csv_field_numeric_classifier_core regression: fail");
    end
    $finish;
  end

endmodule

/* csv_field_numeric_classifier_core.f */
rtl/core/csvfnc_pkg.sv
rtl/core/csv_field_numeric_classifier_core.sv
tb/csv_field_numeric_classifier_core_tb.sv
